@@ rtl/pareto_path_prune_table_defines.svh @@
// Assertion macros shared by the table logic.
`ifndef PARETO_PATH_PRUNE_TABLE_DEFINES_SVH
`define PARETO_PATH_PRUNE_TABLE_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define PPT_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled in reset.
`define PPT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/ppt_pkg.sv @@
`timescale 1ns / 1ps
package ppt_pkg;

   localparam int CSR_INDEX_W = 2;
   localparam int SLOT_W      = 4;

   typedef enum logic [1:0] {
      OP_CHECK    = 2'd0,
      OP_INSERT   = 2'd1,
      OP_QUERY    = 2'd2,
      OP_RESERVED = 2'd3
   } op_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_COST_BUDGET   = 2'd0,
      CSR_MIN_COST      = 2'd1,
      CSR_HAS_NEXT_LEAF = 2'd2,
      CSR_LEAF_BOUND    = 2'd3
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_BOUND,
      ST_SCAN,
      ST_INSERT,
      ST_RESP
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic load;    // capture request, clear result
      logic bound;   // budget / reward bound test
      logic scan;    // one step of the table walk
      logic finish;  // close the walk
      logic insert;  // append one entry
   } ctl_type;

   // datapath -> controller
   typedef struct packed {
      logic bound_prune;
      logic scan_done;
   } sts_type;

endpackage

@@ rtl/ppt_ctrl.sv @@
`timescale 1ns / 1ps
`include "pareto_path_prune_table_defines.svh"
module ppt_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [1:0]        req_operation,
   input  ppt_pkg::sts_type  sts,
   output ppt_pkg::ctl_type  ctl,
   output logic              busy,
   output logic              rsp_valid
);

   ppt_pkg::state_type state_ff;
   ppt_pkg::state_type state_in;
   ppt_pkg::op_type    op;

   assign op = ppt_pkg::op_type'(req_operation);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ppt_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      ctl       = '0;
      busy      = 1'b1;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ppt_pkg::ST_IDLE, ppt_pkg::ST_RESP: begin
            // a new request may land while the result is on the bus
            busy      = 1'b0;
            rsp_valid = (state_ff == ppt_pkg::ST_RESP);
            if (start) begin
               ctl.load = 1'b1;
               unique case (op)
                  ppt_pkg::OP_CHECK:    state_in = ppt_pkg::ST_BOUND;
                  ppt_pkg::OP_INSERT:   state_in = ppt_pkg::ST_INSERT;
                  ppt_pkg::OP_QUERY:    state_in = ppt_pkg::ST_SCAN;
                  ppt_pkg::OP_RESERVED: state_in = ppt_pkg::ST_RESP;
               endcase
            end else begin
               state_in = ppt_pkg::ST_IDLE;
            end
         end
         ppt_pkg::ST_BOUND: begin
            ctl.bound = 1'b1;
            state_in  = sts.bound_prune ? ppt_pkg::ST_RESP : ppt_pkg::ST_SCAN;
         end
         ppt_pkg::ST_SCAN: begin
            if (sts.scan_done) begin
               ctl.finish = 1'b1;
               state_in   = ppt_pkg::ST_RESP;
            end else begin
               ctl.scan = 1'b1;
            end
         end
         ppt_pkg::ST_INSERT: begin
            ctl.insert = 1'b1;
            state_in   = ppt_pkg::ST_RESP;
         end
         default: begin
            state_in = ppt_pkg::ST_IDLE;
         end
      endcase
   end

   `PPT_ASSERT_NEXT(a_accept_progress, clock, reset, start && !busy, busy || rsp_valid, "accepted request neither runs nor answers")
   `PPT_ASSERT_NEXT(a_strobe_single, clock, reset, rsp_valid && !start, !rsp_valid, "result strobe repeated without a request")

endmodule

@@ rtl/ppt_datapath.sv @@
`timescale 1ns / 1ps
`include "pareto_path_prune_table_defines.svh"
module ppt_datapath #(
   parameter int TABLE_DEPTH = 16,
   parameter int VALUE_WIDTH = 32,
   parameter int TAG_WIDTH   = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wr_en,
   input  logic [ppt_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [VALUE_WIDTH-1:0]            csr_wr_data,
   input  logic [1:0]                        req_operation,
   input  logic [VALUE_WIDTH-2:0]            req_path_cost,
   input  logic signed [VALUE_WIDTH-1:0]     req_path_reward,
   input  logic signed [VALUE_WIDTH-1:0]     req_greedy_reward,
   input  logic signed [VALUE_WIDTH-1:0]     req_least_reward,
   input  logic [TAG_WIDTH-1:0]              req_path_tag,
   input  ppt_pkg::ctl_type                  ctl,
   output ppt_pkg::sts_type                  sts,
   output logic                              rsp_prune,
   output logic [ppt_pkg::SLOT_W-1:0]        rsp_slot,
   output logic                              rsp_overflow,
   output logic                              rsp_best_found,
   output logic [VALUE_WIDTH-2:0]            rsp_best_cost,
   output logic signed [VALUE_WIDTH-1:0]     rsp_best_reward,
   output logic [TAG_WIDTH-1:0]              rsp_best_tag
);

   localparam int COST_W  = VALUE_WIDTH - 1;
   localparam int IDX_W   = $clog2(TABLE_DEPTH);
   localparam int CNT_W   = $clog2(TABLE_DEPTH + 1);
   localparam int ENTRY_W = COST_W + VALUE_WIDTH + TAG_WIDTH;
   localparam int REW_LSB = COST_W;
   localparam int TAG_LSB = COST_W + VALUE_WIDTH;

   // configuration
   logic [COST_W-1:0]             budget_ff;
   logic [COST_W-1:0]             min_cost_ff;
   logic                          has_next_ff;
   logic signed [VALUE_WIDTH-1:0] leaf_bound_ff;

   // captured request
   ppt_pkg::op_type               op_ff;
   logic [COST_W-1:0]             cost_ff;
   logic signed [VALUE_WIDTH-1:0] reward_ff;
   logic signed [VALUE_WIDTH-1:0] greedy_ff;
   logic signed [VALUE_WIDTH-1:0] least_ff;
   logic [TAG_WIDTH-1:0]          tag_ff;

   // table and walk control
   logic [ENTRY_W-1:0]            mem [TABLE_DEPTH];
   logic [ENTRY_W-1:0]            rdata_ff;
   logic [CNT_W-1:0]              count_ff, count_in;
   logic [CNT_W-1:0]              rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]              wr_ptr_ff, wr_ptr_in;
   logic                          pv_ff, pv_in;
   logic                          hit_ff, hit_in;

   // result
   logic                          prune_ff, prune_in;
   logic [ppt_pkg::SLOT_W-1:0]    slot_ff, slot_in;
   logic                          overflow_ff, overflow_in;
   logic                          found_ff, found_in;
   logic [COST_W-1:0]             best_cost_ff, best_cost_in;
   logic signed [VALUE_WIDTH-1:0] best_reward_ff, best_reward_in;
   logic [TAG_WIDTH-1:0]          best_tag_ff, best_tag_in;

   logic                          mem_we;
   logic [IDX_W-1:0]              mem_waddr;
   logic [ENTRY_W-1:0]            mem_wdata;
   logic                          rd_issue;

   logic [COST_W-1:0]             e_cost;
   logic signed [VALUE_WIDTH-1:0] e_reward;
   logic [TAG_WIDTH-1:0]          e_tag;
   logic                          e_dom;
   logic                          e_sub;

   logic [VALUE_WIDTH-1:0]        budget_sum;
   logic                          budget_fail;
   logic signed [VALUE_WIDTH:0]   leaf_sum;
   logic signed [VALUE_WIDTH:0]   least_ext;
   logic signed [VALUE_WIDTH:0]   greedy_ext;
   logic                          bound_hit;

   always_ff @(posedge clock) begin
      if (reset) begin
         budget_ff     <= '1;
         min_cost_ff   <= '0;
         has_next_ff   <= 1'b0;
         leaf_bound_ff <= '0;
      end else if (csr_wr_en) begin
         unique case (ppt_pkg::csr_index_type'(csr_index))
            ppt_pkg::CSR_COST_BUDGET:   budget_ff     <= csr_wr_data[COST_W-1:0];
            ppt_pkg::CSR_MIN_COST:      min_cost_ff   <= csr_wr_data[COST_W-1:0];
            ppt_pkg::CSR_HAS_NEXT_LEAF: has_next_ff   <= csr_wr_data[0];
            ppt_pkg::CSR_LEAF_BOUND:    leaf_bound_ff <= csr_wr_data;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         op_ff     <= ppt_pkg::op_type'(req_operation);
         cost_ff   <= req_path_cost;
         reward_ff <= req_path_reward;
         greedy_ff <= req_greedy_reward;
         least_ff  <= req_least_reward;
         tag_ff    <= req_path_tag;
      end
   end

   // entry fields from the registered read port
   assign e_cost   = rdata_ff[COST_W-1:0];
   assign e_reward = rdata_ff[REW_LSB +: VALUE_WIDTH];
   assign e_tag    = rdata_ff[TAG_LSB +: TAG_WIDTH];
   assign e_dom    = (e_cost <= cost_ff) && (e_reward >= reward_ff);
   assign e_sub    = (e_cost > cost_ff) && (e_reward < reward_ff);

   // budget and reward bound, widened by one bit
   assign budget_sum  = {1'b0, cost_ff} + {1'b0, min_cost_ff};
   assign budget_fail = budget_sum > {1'b0, budget_ff};
   assign leaf_sum    = {reward_ff[VALUE_WIDTH-1], reward_ff}
                      + {leaf_bound_ff[VALUE_WIDTH-1], leaf_bound_ff};
   assign least_ext   = {least_ff[VALUE_WIDTH-1], least_ff};
   assign greedy_ext  = {greedy_ff[VALUE_WIDTH-1], greedy_ff};
   assign bound_hit   = (count_ff != '0) && has_next_ff
                      && ((least_ext > leaf_sum) || (greedy_ext >= leaf_sum));

   assign sts.bound_prune = budget_fail || bound_hit;
   assign sts.scan_done   = (rd_ptr_ff == count_ff) && !pv_ff;

   assign rd_issue = ctl.scan && (rd_ptr_ff != count_ff);

   always_comb begin
      count_in       = count_ff;
      rd_ptr_in      = rd_ptr_ff;
      wr_ptr_in      = wr_ptr_ff;
      pv_in          = pv_ff;
      hit_in         = hit_ff;
      prune_in       = prune_ff;
      slot_in        = slot_ff;
      overflow_in    = overflow_ff;
      found_in       = found_ff;
      best_cost_in   = best_cost_ff;
      best_reward_in = best_reward_ff;
      best_tag_in    = best_tag_ff;
      mem_we         = 1'b0;
      mem_waddr      = wr_ptr_ff[IDX_W-1:0];
      mem_wdata      = rdata_ff;

      if (ctl.load) begin
         rd_ptr_in      = '0;
         wr_ptr_in      = '0;
         pv_in          = 1'b0;
         hit_in         = 1'b0;
         prune_in       = 1'b0;
         slot_in        = '0;
         overflow_in    = 1'b0;
         found_in       = 1'b0;
         best_cost_in   = '0;
         best_reward_in = '0;
         best_tag_in    = '0;
      end

      if (ctl.bound) begin
         prune_in = sts.bound_prune;
      end

      if (ctl.scan) begin
         if (rd_issue) begin
            rd_ptr_in = rd_ptr_ff + CNT_W'(1);
         end
         pv_in = rd_issue;
         if (pv_ff) begin
            if (op_ff == ppt_pkg::OP_QUERY) begin
               // best_reward starts at zero, so only positive rewards win
               if (e_reward > best_reward_ff) begin
                  found_in       = 1'b1;
                  best_cost_in   = e_cost;
                  best_reward_in = e_reward;
                  best_tag_in    = e_tag;
               end
            end else begin
               // compact in place; after a hit the rest is copied as is
               if (hit_ff || e_dom || !e_sub) begin
                  mem_we    = 1'b1;
                  wr_ptr_in = wr_ptr_ff + CNT_W'(1);
               end
               if (e_dom) begin
                  hit_in = 1'b1;
               end
            end
         end
      end

      if (ctl.finish && (op_ff == ppt_pkg::OP_CHECK)) begin
         count_in = wr_ptr_ff;
         prune_in = hit_ff;
      end

      if (ctl.insert) begin
         if (count_ff == CNT_W'(TABLE_DEPTH)) begin
            overflow_in = 1'b1;
         end else begin
            mem_we    = 1'b1;
            mem_waddr = count_ff[IDX_W-1:0];
            mem_wdata = {tag_ff, reward_ff, cost_ff};
            slot_in   = ppt_pkg::SLOT_W'(count_ff);
            count_in  = count_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
         pv_ff     <= 1'b0;
         hit_ff    <= 1'b0;
      end else begin
         count_ff  <= count_in;
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         pv_ff     <= pv_in;
         hit_ff    <= hit_in;
      end
   end

   always_ff @(posedge clock) begin
      prune_ff       <= prune_in;
      slot_ff        <= slot_in;
      overflow_ff    <= overflow_in;
      found_ff       <= found_in;
      best_cost_ff   <= best_cost_in;
      best_reward_ff <= best_reward_in;
      best_tag_ff    <= best_tag_in;
   end

   // entry store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (rd_issue) begin
         rdata_ff <= mem[rd_ptr_ff[IDX_W-1:0]];
      end
   end

   assign rsp_prune       = prune_ff;
   assign rsp_slot        = slot_ff;
   assign rsp_overflow    = overflow_ff;
   assign rsp_best_found  = found_ff;
   assign rsp_best_cost   = best_cost_ff;
   assign rsp_best_reward = best_reward_ff;
   assign rsp_best_tag    = best_tag_ff;

   `PPT_ASSERT_SAME(a_count_range, clock, reset, 1'b1, count_ff <= CNT_W'(TABLE_DEPTH), "entry count beyond table depth")
   `PPT_ASSERT_SAME(a_compact_order, clock, reset, 1'b1, wr_ptr_ff <= rd_ptr_ff, "compaction write overtook the read")

endmodule

@@ rtl/pareto_path_prune_table.sv @@
`timescale 1ns / 1ps
// A new start is taken in the rsp_valid cycle, so a request is accepted only once the last
//   one is answered; the entry walk (one registered read per cycle) sets how long it runs.
// Reset (synchronous, active high): table empties, configuration and walk registers take
//   reset values; request and result registers are not reset.
// Results are a one-cycle strobe; the receiver cannot stall.
module pareto_path_prune_table #(
   parameter int TABLE_DEPTH = 16,
   parameter int VALUE_WIDTH = 32,
   parameter int TAG_WIDTH   = 16
) (
   input  logic                              clock,
   input  logic                              reset,

   // configuration write port
   input  logic                              csr_wr_en,
   input  logic [ppt_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [VALUE_WIDTH-1:0]            csr_wr_data,

   // request: transfer on start && !busy
   input  logic                              start,
   output logic                              busy,
   input  logic [1:0]                        req_operation,
   input  logic [VALUE_WIDTH-2:0]            req_path_cost,
   input  logic signed [VALUE_WIDTH-1:0]     req_path_reward,
   input  logic signed [VALUE_WIDTH-1:0]     req_greedy_reward,
   input  logic signed [VALUE_WIDTH-1:0]     req_least_reward,
   input  logic [TAG_WIDTH-1:0]              req_path_tag,

   // response: transfer on rsp_valid, one cycle
   output logic                              rsp_valid,
   output logic                              rsp_prune,
   output logic [ppt_pkg::SLOT_W-1:0]        rsp_slot,
   output logic                              rsp_overflow,
   output logic                              rsp_best_found,
   output logic [VALUE_WIDTH-2:0]            rsp_best_cost,
   output logic signed [VALUE_WIDTH-1:0]     rsp_best_reward,
   output logic [TAG_WIDTH-1:0]              rsp_best_tag
);

   // The controller sequences each request:
   //   check : the budget and reward-bound test; unless that prunes, a walk over
   //           the table. The walk reads one entry per cycle and writes the kept
   //           entries back at a trailing pointer, which drops entries that the
   //           candidate strictly dominates. After the first dominating entry
   //           the walk keeps copying so the table stays packed; the entry
   //           count then takes the trailing pointer.
   //   insert: append at the current count, or flag overflow on a full table.
   //   query : the same walk, read-only, keeping the first largest positive
   //           reward.
   // Result fields are cleared at every request, so fields that do not
   // belong to the operation read zero.

   ppt_pkg::ctl_type ctl;
   ppt_pkg::sts_type sts;

   ppt_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .req_operation (req_operation),
      .sts           (sts),
      .ctl           (ctl),
      .busy          (busy),
      .rsp_valid     (rsp_valid)
   );

   ppt_datapath #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .VALUE_WIDTH (VALUE_WIDTH),
      .TAG_WIDTH   (TAG_WIDTH)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wr_data       (csr_wr_data),
      .req_operation     (req_operation),
      .req_path_cost     (req_path_cost),
      .req_path_reward   (req_path_reward),
      .req_greedy_reward (req_greedy_reward),
      .req_least_reward  (req_least_reward),
      .req_path_tag      (req_path_tag),
      .ctl               (ctl),
      .sts               (sts),
      .rsp_prune         (rsp_prune),
      .rsp_slot          (rsp_slot),
      .rsp_overflow      (rsp_overflow),
      .rsp_best_found    (rsp_best_found),
      .rsp_best_cost     (rsp_best_cost),
      .rsp_best_reward   (rsp_best_reward),
      .rsp_best_tag      (rsp_best_tag)
   );

endmodule
